// ----- rtl/core/gtt_pkg.sv -----
package gtt_pkg;

  // Default file size bound; the saturation points of the counters follow from it
  localparam int unsigned MAX_FILE_BYTES_DEF = 32'd8388608;

  localparam int unsigned LINE_W = 24;
  localparam int unsigned COL_W  = 23;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned RECS   = 3;   // record slots per byte; one byte causes at most two

  // Scanner modes; the eighth code is unused and behaves as idle
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_LINEC = 3'd2,
    MODE_BLOCK = 3'd3,
    MODE_STR   = 3'd4,
    MODE_NUM   = 3'd5,
    MODE_IDENT = 3'd6
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NUM   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CMT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PUNCT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OP    = 3'd5;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic [KIND_W-1:0] kind;
  } rec_t;

  // All token records caused by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [RECS-1:0] rec;
  } grp_t;

endpackage

// ----- rtl/core/gtt_scan.sv -----
module gtt_scan #(
  parameter int unsigned MAX_FILE_BYTES = gtt_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,       // commit the byte below
  input  logic [7:0]   data_byte,
  input  logic         is_last,
  output gtt_pkg::grp_t grp        // records this byte causes
);

  localparam longint unsigned MFB = longint'(MAX_FILE_BYTES);
  localparam longint unsigned LINE_CAP_L = (MFB + 64'd1 < 64'hFFFFFF) ? MFB + 64'd1 : 64'hFFFFFF;
  localparam longint unsigned COL_CAP_L  = (MFB - 64'd1 < 64'h7FFFFF) ? MFB - 64'd1 : 64'h7FFFFF;
  localparam longint unsigned LEN_CAP_L  = (MFB < 64'hFFFFFF) ? MFB : 64'hFFFFFF;
  localparam logic [gtt_pkg::LINE_W-1:0] LINE_CAP = LINE_CAP_L[gtt_pkg::LINE_W-1:0];
  localparam logic [gtt_pkg::COL_W-1:0]  COL_CAP  = COL_CAP_L[gtt_pkg::COL_W-1:0];
  localparam logic [gtt_pkg::LEN_W-1:0]  LEN_CAP  = LEN_CAP_L[gtt_pkg::LEN_W-1:0];
  localparam logic [gtt_pkg::LINE_W-1:0] LINE_ONE = {{(gtt_pkg::LINE_W-1){1'b0}}, 1'b1};
  localparam logic [gtt_pkg::LEN_W-1:0]  LEN_ONE  = {{(gtt_pkg::LEN_W-1){1'b0}}, 1'b1};

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UND   = 8'h5F;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == 8'h28) || (b == 8'h29) || (b == 8'h5B) || (b == 8'h5D) ||
           (b == 8'h7B) || (b == 8'h7D) || (b == 8'h3B) || (b == 8'h2C) || (b == CH_DOT);
  endfunction

  gtt_pkg::mode_t               mode_r, mode_nxt;
  logic [gtt_pkg::LINE_W-1:0]   line_r, line_nxt;
  logic [gtt_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [gtt_pkg::LINE_W-1:0]   oline_r, oline_nxt;
  logic [gtt_pkg::COL_W-1:0]    ocol_r, ocol_nxt;
  logic [gtt_pkg::LEN_W-1:0]    olen_r, olen_nxt;
  logic                         qsingle_r, qsingle_nxt;
  logic                         esc_r, esc_nxt;
  logic                         star_r, star_nxt;
  logic                         inblk_r, inblk_nxt;

  always_comb begin
    logic                  fresh;   // byte falls through to the idle decoder
    logic [1:0]            n;
    gtt_pkg::rec_t [2:0]   rec;
    logic [gtt_pkg::KIND_W-1:0] fk;
    logic                  fl;

    mode_nxt    = mode_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    oline_nxt   = oline_r;
    ocol_nxt    = ocol_r;
    olen_nxt    = olen_r;
    qsingle_nxt = qsingle_r;
    esc_nxt     = esc_r;
    star_nxt    = star_r;
    inblk_nxt   = inblk_r;
    fresh       = 1'b1;
    n           = 2'd0;
    rec         = '0;
    fk          = gtt_pkg::KIND_OP;
    fl          = 1'b0;

    // Close or extend the open token
    unique case (mode_r)
      gtt_pkg::MODE_SLASH: begin
        if (data_byte == CH_SLASH || data_byte == CH_STAR) begin
          if (data_byte == CH_SLASH) begin
            mode_nxt = gtt_pkg::MODE_LINEC;
          end else begin
            mode_nxt  = gtt_pkg::MODE_BLOCK;
            inblk_nxt = 1'b1;
            star_nxt  = 1'b0;
          end
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          fresh = 1'b0;
        end else begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_OP};
          n = n + 2'd1;
        end
      end
      gtt_pkg::MODE_LINEC: begin
        if (data_byte != CH_NL) begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          fresh = 1'b0;
        end else begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_CMT};
          n = n + 2'd1;
        end
      end
      gtt_pkg::MODE_BLOCK: begin
        if (data_byte == CH_NL) begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_CMT};
          n = n + 2'd1;
          star_nxt = 1'b0;
        end else begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          if (star_r && data_byte == CH_SLASH) begin
            rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_CMT};
            n = n + 2'd1;
            inblk_nxt = 1'b0;
            star_nxt  = 1'b0;
            mode_nxt  = gtt_pkg::MODE_IDLE;
          end else begin
            star_nxt = (data_byte == CH_STAR);
          end
          fresh = 1'b0;
        end
      end
      gtt_pkg::MODE_STR: begin
        if (esc_r) begin
          // escaped byte, newline included, joins the string
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          esc_nxt = 1'b0;
          fresh   = 1'b0;
        end else if (data_byte == (qsingle_r ? CH_SQ : CH_DQ)) begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_STR};
          n = n + 2'd1;
          mode_nxt = gtt_pkg::MODE_IDLE;
          fresh    = 1'b0;
        end else if (data_byte == CH_NL) begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_STR};
          n = n + 2'd1;
        end else begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          esc_nxt = (data_byte == CH_BSL);
          fresh   = 1'b0;
        end
      end
      gtt_pkg::MODE_NUM: begin
        if (is_digit(data_byte) || is_alpha(data_byte) || data_byte == CH_DOT ||
            data_byte == CH_UND) begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          fresh = 1'b0;
        end else begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_NUM};
          n = n + 2'd1;
        end
      end
      gtt_pkg::MODE_IDENT: begin
        if (is_digit(data_byte) || is_alpha(data_byte) || data_byte == CH_UND ||
            data_byte[7]) begin
          if (olen_nxt < LEN_CAP) olen_nxt = olen_nxt + 1'b1;
          if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
          fresh = 1'b0;
        end else begin
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, gtt_pkg::KIND_IDENT};
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase

    // Decode the byte as the start of something new
    if (fresh) begin
      mode_nxt = gtt_pkg::MODE_IDLE;
      if (data_byte == CH_NL) begin
        if (line_nxt < LINE_CAP) line_nxt = line_nxt + 1'b1;
        col_nxt = '0;
      end else begin
        priority if (inblk_nxt) begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt  = gtt_pkg::MODE_BLOCK;
          star_nxt  = (data_byte == CH_STAR);
        end else if (data_byte == CH_SPACE || data_byte == CH_TAB || data_byte == CH_CR) begin
          // whitespace is dropped
        end else if (data_byte == CH_HASH) begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt  = gtt_pkg::MODE_LINEC;
        end else if (data_byte == CH_SLASH) begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt  = gtt_pkg::MODE_SLASH;
        end else if (data_byte == CH_DQ || data_byte == CH_SQ) begin
          oline_nxt   = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt    = gtt_pkg::MODE_STR;
          qsingle_nxt = (data_byte == CH_SQ);
          esc_nxt     = 1'b0;
        end else if (is_digit(data_byte)) begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt  = gtt_pkg::MODE_NUM;
        end else if (is_alpha(data_byte) || data_byte == CH_UND || data_byte[7]) begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          mode_nxt  = gtt_pkg::MODE_IDENT;
        end else begin
          oline_nxt = line_nxt; ocol_nxt = col_nxt; olen_nxt = LEN_ONE;
          rec[n] = '{oline_nxt, ocol_nxt, olen_nxt,
                     is_punct(data_byte) ? gtt_pkg::KIND_PUNCT : gtt_pkg::KIND_OP};
          n = n + 2'd1;
        end
        if (col_nxt < COL_CAP) col_nxt = col_nxt + 1'b1;
      end
    end

    // End of file: flush the open token and start over
    if (is_last) begin
      unique case (mode_nxt)
        gtt_pkg::MODE_SLASH: begin fl = 1'b1; fk = gtt_pkg::KIND_OP;    end
        gtt_pkg::MODE_LINEC: begin fl = 1'b1; fk = gtt_pkg::KIND_CMT;   end
        gtt_pkg::MODE_BLOCK: begin fl = 1'b1; fk = gtt_pkg::KIND_CMT;   end
        gtt_pkg::MODE_STR:   begin fl = 1'b1; fk = gtt_pkg::KIND_STR;   end
        gtt_pkg::MODE_NUM:   begin fl = 1'b1; fk = gtt_pkg::KIND_NUM;   end
        gtt_pkg::MODE_IDENT: begin fl = 1'b1; fk = gtt_pkg::KIND_IDENT; end
        default:             begin fl = 1'b0; fk = gtt_pkg::KIND_OP;    end
      endcase
      if (fl) begin
        rec[n] = '{oline_nxt, ocol_nxt, olen_nxt, fk};
        n = n + 2'd1;
      end
      mode_nxt    = gtt_pkg::MODE_IDLE;
      line_nxt    = LINE_ONE;
      col_nxt     = '0;
      oline_nxt   = LINE_ONE;
      ocol_nxt    = '0;
      olen_nxt    = '0;
      qsingle_nxt = 1'b0;
      esc_nxt     = 1'b0;
      star_nxt    = 1'b0;
      inblk_nxt   = 1'b0;
    end

    grp.cnt = n;
    grp.rec = rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= gtt_pkg::MODE_IDLE;
      line_r    <= LINE_ONE;
      col_r     <= '0;
      oline_r   <= LINE_ONE;
      ocol_r    <= '0;
      olen_r    <= '0;
      qsingle_r <= 1'b0;
      esc_r     <= 1'b0;
      star_r    <= 1'b0;
      inblk_r   <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      oline_r   <= oline_nxt;
      ocol_r    <= ocol_nxt;
      olen_r    <= olen_nxt;
      qsingle_r <= qsingle_nxt;
      esc_r     <= esc_nxt;
      star_r    <= star_nxt;
      inblk_r   <= inblk_nxt;
    end
  end

endmodule

// ----- rtl/core/gtt_out.sv -----
module gtt_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              grp_vld,   // a byte waits to be scanned
  input  gtt_pkg::grp_t                     grp_in,
  output logic                              grp_load,  // scan it and take its records
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output gtt_pkg::rec_t                     out_rec,
  output logic                              out_last
);

  logic [1:0]                        cnt_r;
  gtt_pkg::rec_t [gtt_pkg::RECS-1:0] rec_r;
  logic [1:0]                        idx_r;
  logic                              take;
  logic                              at_end;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_rec    = rec_r[idx_r];
  assign at_end     = (idx_r == cnt_r - 2'd1);
  assign out_last   = at_end;
  assign take       = out_tvalid && out_tready;
  assign grp_load   = grp_vld && (!out_tvalid || (take && at_end));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (grp_load) begin
      cnt_r <= grp_in.cnt;
      idx_r <= 2'd0;
    end else if (take) begin
      if (at_end) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      rec_r <= grp_in.rec;
    end
  end

endmodule

// ----- rtl/core/generic_text_tokenizer_unit.sv -----
// Text tokenizer for syntax highlighting.
// Input channel (in_*): one text byte per word, in_tlast on the final byte
// of a file. Output channel (out_*): one token record per word, with
// out_tuser giving the token kind and out_tlast marking the last record
// caused by one input byte.
// A byte accepted into the input register is scanned into the result register
// as soon as that register is free; its records are then offered from the
// result register, one at a time.
// Throughput: one byte per cycle while each byte causes at most one record
// and the receiver is ready; a byte causing more records holds the input
// until the single output port has drained the result register.
// Bytes causing no record pass at one per cycle.
// The final byte of a file flushes any open token and returns the scanner
// to line 1, column 0, idle, ready for the next file.
// Reset (rst_n low at a clock edge) empties both registers and clears the
// scanner state. When the receiver stalls, the result register holds its
// records and the input register holds one more byte; in_tready then drops.
module generic_text_tokenizer_unit #(
  parameter int unsigned MAX_FILE_BYTES = gtt_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [23:0] line_number, [46:24] start_column,
                                  // [70:47] token_length, [71] zero
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // run_end
);

  // Input register
  logic       byte_vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       grp_load;
  logic       in_take;

  gtt_pkg::grp_t grp;
  gtt_pkg::rec_t rec;

  assign in_tready = !byte_vld_r || grp_load;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_take) begin
      byte_vld_r <= 1'b1;
    end else if (grp_load) begin
      byte_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Scanner state advances exactly when its records move to the result register
  gtt_scan #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (grp_load),
    .data_byte (byte_r),
    .is_last   (last_r),
    .grp       (grp)
  );

  gtt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_vld    (byte_vld_r),
    .grp_in     (grp),
    .grp_load   (grp_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rec    (rec),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, rec.len, rec.col, rec.line};
  assign out_tuser = rec.kind;

endmodule
